### rtl/mwh_pkg.sv
// ----------------------------------------------------------------------------
// mwh_pkg: shared types and constants for the word-stream murmur3 hash
// Item format passed from the classifier to the hash engine, engine states
// and the murmur3 x86_32 mixing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package mwh_pkg;

    // Key word and byte-count widths
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned NBYTE_W = 3;
    localparam int unsigned TDATA_IN_W  = 40;  // word + byte count, padded to bytes
    localparam int unsigned TDATA_OUT_W = 32;

    // Bytes in a full word
    localparam logic [NBYTE_W-1:0] FULL_BYTES = 3'd4;

    // Reset value of the seed register
    localparam logic [WORD_W-1:0] SEED_RESET = 32'hbebeb0ba;

    // murmur3 constants
    localparam logic [WORD_W-1:0] MUR_C1  = 32'hcc9e2d51;
    localparam logic [WORD_W-1:0] MUR_C2  = 32'h1b873593;
    localparam logic [WORD_W-1:0] MUR_ADD = 32'he6546b64;
    localparam logic [WORD_W-1:0] MUR_F1  = 32'h85ebca6b;
    localparam logic [WORD_W-1:0] MUR_F2  = 32'hc2b2ae35;

    // Classified item: masked key word and how the engine must use it
    typedef struct packed {
        logic [WORD_W-1:0]  word;       // bytes beyond the valid count zeroed
        logic [NBYTE_W-1:0] add_bytes;  // added to the byte count
        logic               full;       // 1: body mix, 0: tail XOR
        logic               last;       // finalize after this item
    } t_item;

    // Configuration write as seen by the engine
    typedef struct packed {
        logic              wr;
        logic [WORD_W-1:0] data;
    } t_cfg;

    // Hash engine sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCR2,
        ST_MIX,
        ST_FIN1,
        ST_FIN2,
        ST_OUT
    } t_state;

    // Rotate left by a fixed amount
    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v,
                                               input int unsigned s);
        rotl = (v << s) | (v >> (WORD_W - s));
    endfunction

endpackage

`default_nettype wire

### rtl/murmur3_word_hash.sv
// ----------------------------------------------------------------------------
// murmur3_word_hash: streaming MurmurHash3 x86_32 over 32-bit key words
// Key words enter on the s_axis channel, one hash per key leaves on m_axis.
//
// Input tdata: data_word in bits 31:0 (first key byte in 7:0), valid_bytes
// in bits 34:32, zero padding above. tlast marks the final word of a key;
// only that word honors valid_bytes (0..4, higher values count as 4).
// Output tdata: the 32-bit finalized hash. One transfer per key.
// The cfg channel writes the seed; a write also restarts the key state.
// Issue it only while no key is in flight; the block does not enforce this.
// A two-entry queue sits behind s_axis, so input transfers continue while
// the engine works or the output waits. The engine takes each non-last word
// through two scramble multiplies, then the mix, and the last word also
// through two finalizer multiplies and the output load; the multiplier
// steps set the rate. A last word passes through the queue, the scramble,
// mix and finalizer steps and the output register before its hash shows on
// m_axis. If m_axis stalls, the result holds and the engine waits with the
// next finished hash; the queue then fills and s_axis backs up.
// Reset loads the seed 0xbebeb0ba, clears the byte count and empties queue.
// ----------------------------------------------------------------------------
`default_nettype none

module murmur3_word_hash (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Seed write
    input  wire logic                              i_cfg_valid,
    output      logic                              o_cfg_ready,
    input  wire logic [mwh_pkg::WORD_W-1:0]        i_cfg_data,
    // Key words
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    input  wire logic [mwh_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,  // data_word, valid_bytes
    input  wire logic                              i_s_axis_tlast,  // last
    // Hash results
    output      logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output      logic [mwh_pkg::TDATA_OUT_W-1:0]   o_m_axis_tdata   // hash
);

    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_valid;
    mwh_pkg::t_item front_item;
    mwh_pkg::t_item head_item;
    mwh_pkg::t_cfg  cfg;

    // Seed writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg.wr      = i_cfg_valid;
    assign cfg.data    = i_cfg_data;

    mwh_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_item          (front_item)
    );

    mwh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    mwh_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_q_valid       (q_valid),
        .i_item          (head_item),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

### rtl/mwh_front.sv
// ----------------------------------------------------------------------------
// mwh_front: input classifier
// Takes stream transfers, saturates the byte count, masks unused bytes and
// decides between a body mix and a tail XOR before queueing the item.
// ----------------------------------------------------------------------------
`default_nettype none

module mwh_front (
    input  wire logic                              i_s_axis_tvalid,
    output      logic                              o_s_axis_tready,
    input  wire logic [mwh_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,
    input  wire logic                              i_s_axis_tlast,
    input  wire logic                              i_q_full,
    output      logic                              o_push,
    output      mwh_pkg::t_item                    o_item
);

    logic [mwh_pkg::WORD_W-1:0]  word;
    logic [mwh_pkg::NBYTE_W-1:0] vb;
    logic [mwh_pkg::NBYTE_W-1:0] nb;

    assign word = i_s_axis_tdata[mwh_pkg::WORD_W-1:0];
    assign vb   = i_s_axis_tdata[mwh_pkg::WORD_W +: mwh_pkg::NBYTE_W];

    // Accept whenever the queue has room
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    // Counts above four saturate
    assign nb = (vb > mwh_pkg::FULL_BYTES) ? mwh_pkg::FULL_BYTES : vb;

    // Classification; non-last words always count as four bytes
    always_comb begin
        o_item.last = i_s_axis_tlast;
        if (!i_s_axis_tlast) begin
            o_item.full      = 1'b1;
            o_item.add_bytes = mwh_pkg::FULL_BYTES;
            o_item.word      = word;
        end else begin
            o_item.full      = (nb == mwh_pkg::FULL_BYTES);
            o_item.add_bytes = nb;
            case (nb)
                3'd0:    o_item.word = '0;
                3'd1:    o_item.word = {24'd0, word[7:0]};
                3'd2:    o_item.word = {16'd0, word[15:0]};
                3'd3:    o_item.word = {8'd0, word[23:0]};
                default: o_item.word = word;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/mwh_queue.sv
// ----------------------------------------------------------------------------
// mwh_queue: two-entry item queue
// Decouples the classifier from the hash engine so each side stalls alone.
// ----------------------------------------------------------------------------
`default_nettype none

module mwh_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire mwh_pkg::t_item  i_item,
    input  wire logic            i_pop,
    output      logic            o_full,
    output      logic            o_valid,
    output      mwh_pkg::t_item  o_item
);

    mwh_pkg::t_item r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && r_count == 2'd2))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && r_count == 2'd0))
        else $error("queue read while empty");

endmodule

`default_nettype wire

### rtl/mwh_back.sv
// ----------------------------------------------------------------------------
// mwh_back: murmur3 hash engine
// Sequencer, at most one registered multiply per step: scramble, mix into the
// running hash, and on the last item the fmix32 finalizer and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mwh_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mwh_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_q_valid,
    input  wire mwh_pkg::t_item                     i_item,
    output      logic                               o_pop,
    output      logic                               o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    output      logic [mwh_pkg::TDATA_OUT_W-1:0]    o_m_axis_tdata
);

    mwh_pkg::t_state              r_state, n_state;
    logic [mwh_pkg::WORD_W-1:0]   r_seed;
    logic [mwh_pkg::WORD_W-1:0]   r_rh;
    logic [mwh_pkg::WORD_W-1:0]   r_cnt;
    logic [mwh_pkg::WORD_W-1:0]   r_k;
    logic [mwh_pkg::WORD_W-1:0]   r_h;
    logic [mwh_pkg::WORD_W-1:0]   r_out;
    logic                         r_ov;
    logic [mwh_pkg::NBYTE_W-1:0]  r_add;
    logic                         r_full;
    logic                         r_last;
    logic                         out_free;
    logic                         out_load;
    logic [mwh_pkg::WORD_W-1:0]   mix_x;
    logic [mwh_pkg::WORD_W-1:0]   fin_x;

    assign out_free        = !r_ov || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_out;

    // Body mix input and finalizer input
    assign mix_x = mwh_pkg::rotl(r_rh ^ r_k, 13);
    assign fin_x = (r_rh ^ r_cnt) ^ ((r_rh ^ r_cnt) >> 16);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mwh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and step controls
    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            mwh_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_state = mwh_pkg::ST_SCR2;
                end
            end
            mwh_pkg::ST_SCR2: n_state = mwh_pkg::ST_MIX;
            mwh_pkg::ST_MIX:  n_state = r_last ? mwh_pkg::ST_FIN1 : mwh_pkg::ST_IDLE;
            mwh_pkg::ST_FIN1: n_state = mwh_pkg::ST_FIN2;
            mwh_pkg::ST_FIN2: n_state = mwh_pkg::ST_OUT;
            mwh_pkg::ST_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = mwh_pkg::ST_IDLE;
                end
            end
            default: n_state = mwh_pkg::ST_IDLE;
        endcase
    end

    // Key state: seed, running hash, byte count, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= mwh_pkg::SEED_RESET;
            r_rh   <= mwh_pkg::SEED_RESET;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (r_state == mwh_pkg::ST_MIX) begin
                r_rh  <= r_full ? ((mix_x << 2) + mix_x + mwh_pkg::MUR_ADD)
                                : (r_rh ^ r_k);
                r_cnt <= r_cnt + mwh_pkg::WORD_W'(r_add);
            end
            // Reload for the next key once the finalizer has read the state
            if (r_state == mwh_pkg::ST_FIN1) begin
                r_rh  <= r_seed;
                r_cnt <= '0;
            end
            if (i_cfg.wr) begin
                r_seed <= i_cfg.data;
                r_rh   <= i_cfg.data;
                r_cnt  <= '0;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath: at most one multiply per step
    always_ff @(posedge i_clk) begin
        case (r_state)
            mwh_pkg::ST_IDLE: begin
                if (o_pop) begin
                    r_k    <= i_item.word * mwh_pkg::MUR_C1;
                    r_add  <= i_item.add_bytes;
                    r_full <= i_item.full;
                    r_last <= i_item.last;
                end
            end
            mwh_pkg::ST_SCR2: r_k <= mwh_pkg::rotl(r_k, 15) * mwh_pkg::MUR_C2;
            mwh_pkg::ST_FIN1: r_h <= fin_x * mwh_pkg::MUR_F1;
            mwh_pkg::ST_FIN2: r_h <= (r_h ^ (r_h >> 13)) * mwh_pkg::MUR_F2;
            mwh_pkg::ST_OUT: begin
                if (out_load) r_out <= r_h ^ (r_h >> 16);
            end
            default: r_k <= r_k;
        endcase
    end

    a_reload_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mwh_pkg::ST_FIN1) |=> (r_cnt == '0 && r_rh == r_seed))
        else $error("key state not reloaded after finalize");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_ov)
        else $error("finalized hash not presented");

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == mwh_pkg::ST_IDLE && i_q_valid))
        else $error("item taken while engine busy");

endmodule

`default_nettype wire

### bench/murmur3_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur3_hash_checker: scoreboard for the word-stream murmur3 hash
// Watches the seed, key-word and hash channels, runs its own murmur3 x86_32
// model on every accepted key word and compares each hash transfer against
// the oldest predicted hash. Failures are counted and handed to the top.
// ----------------------------------------------------------------------------

module murmur3_hash_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Seed channel
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [mwh_pkg::WORD_W-1:0]        i_cfg_data,
    // Key words
    input  logic                              i_s_axis_tvalid,
    input  logic                              i_s_axis_tready,
    input  logic [mwh_pkg::TDATA_IN_W-1:0]    i_s_axis_tdata,  // data_word, valid_bytes
    input  logic                              i_s_axis_tlast,  // last
    // Hashes
    input  logic                              i_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [mwh_pkg::TDATA_OUT_W-1:0]   i_m_axis_tdata,  // hash
    // End of run: check for hashes never delivered
    input  logic                              i_end,
    output int                                o_pending,
    output int                                o_fail_count
);

    localparam logic [31:0] SEED_INIT  = 32'hbebeb0ba;
    localparam logic [31:0] K_MUL1     = 32'hcc9e2d51;
    localparam logic [31:0] K_MUL2     = 32'h1b873593;
    localparam logic [31:0] H_ADD      = 32'he6546b64;
    localparam logic [31:0] FIN_MUL1   = 32'h85ebca6b;
    localparam logic [31:0] FIN_MUL2   = 32'hc2b2ae35;
    localparam logic [2:0]  WORD_BYTES = 3'd4;

    // Model state
    logic [31:0] seed_val   = SEED_INIT;
    logic [31:0] run_hash   = SEED_INIT;
    logic [31:0] byte_total = '0;
    logic [31:0] hash_expect_q[$];
    logic [31:0] want;
    bit          end_seen   = 1'b0;
    int          fail_total = 0;
    int          hash_idx   = 0;

    assign o_fail_count = fail_total;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [31:0] scramble_key(input logic [31:0] k);
        logic [31:0] t;
        t = k * K_MUL1;
        t = rol32(t, 15);
        return t * K_MUL2;
    endfunction

    // Body step of the hash recurrence
    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rol32(h ^ scramble_key(k), 13);
        return t * 32'd5 + H_ADD;
    endfunction

    function automatic logic [31:0] fmix(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_MUL1;
        t = t ^ (t >> 13);
        t = t * FIN_MUL2;
        return t ^ (t >> 16);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_total++;
    endtask

    // Fold one accepted key word into the model; a last word yields a hash
    task automatic absorb_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
        logic [2:0]  n;
        logic [31:0] keep;
        if (!lst) begin
            run_hash   = mix_word(run_hash, w);
            byte_total = byte_total + WORD_BYTES;
        end else begin
            n = (nb > WORD_BYTES) ? WORD_BYTES : nb;
            if (n == WORD_BYTES) begin
                run_hash = mix_word(run_hash, w);
            end else if (n != 0) begin
                keep     = 32'hffffffff >> (8 * (4 - n));
                run_hash = run_hash ^ scramble_key(w & keep);
            end
            byte_total = byte_total + n;
            hash_expect_q.push_back(fmix(run_hash ^ byte_total));
            run_hash   = seed_val;
            byte_total = '0;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seed_val   = SEED_INIT;
            run_hash   = SEED_INIT;
            byte_total = '0;
            hash_expect_q.delete();
        end else begin
            // seed write restarts the key
            if (i_cfg_valid && i_cfg_ready) begin
                seed_val   = i_cfg_data;
                run_hash   = i_cfg_data;
                byte_total = '0;
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                absorb_word(i_s_axis_tdata[31:0], i_s_axis_tdata[34:32], i_s_axis_tlast);
            // hash transfer against oldest prediction
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (hash_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected hash %08h", i_m_axis_tdata));
                end else begin
                    want = hash_expect_q.pop_front();
                    if (i_m_axis_tdata !== want)
                        report_mismatch($sformatf("hash #%0d: got %08h, want %08h",
                                                  hash_idx, i_m_axis_tdata, want));
                end
                hash_idx++;
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (hash_expect_q.size() != 0)
                    report_mismatch($sformatf("%0d hashes never delivered",
                                              hash_expect_q.size()));
            end
        end
        o_pending <= hash_expect_q.size();
    end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top of the murmur3_word_hash testbench
// Drives seed writes and keys as streams of 32-bit words, with random gaps on
// the input side and random stalls on the hash side; a checker instance
// predicts every hash and the top gives the verdict.
// ----------------------------------------------------------------------------

module tb;

    localparam logic [31:0] SEED_INIT = 32'hbebeb0ba;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_valid;
    logic [31:0] cfg_data;
    logic        s_tvalid;
    logic [mwh_pkg::TDATA_IN_W-1:0] s_tdata;  // data_word, valid_bytes
    logic        s_tlast;                     // last
    logic        m_tready;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [mwh_pkg::TDATA_OUT_W-1:0] m_tdata;  // hash
    logic        run_end;
    int          pending;
    int          fail_count;
    bit          pace_src  = 1'b0;
    bit          pace_sink = 1'b1;

    murmur3_word_hash dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    murmur3_hash_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tlast  (s_tlast),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_end           (run_end),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("FAIL murmur3_word_hash");
        $finish;
    end

    // Hash side: random stall bursts while pacing is on
    initial begin : sink_pacing
        int unsigned gap;
        m_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (pace_sink && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Mostly random words, with all-zero and all-one words mixed in
    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // One key-word transfer; valid stays high between back-to-back words
    task automatic push_word(input logic [31:0] w, input logic [2:0] nb, input logic lst);
        int unsigned gap;
        if (pace_src && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tdata  <= {5'b0, nb, w};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
    endtask

    // Drain: no word in flight, every hash delivered, engine quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned sent;
        int unsigned klen;
        logic [31:0] seed_pick;
        logic [2:0]  tail;

        i_rst_n   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        run_end   <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed keys under the reset seed
        push_word(rand_word(), 3'd0, 1'b1);       // empty key
        push_word(32'hffffffff, 3'd1, 1'b1);      // tails, upper bytes masked
        push_word(32'hffffffff, 3'd2, 1'b1);
        push_word(32'hffffffff, 3'd3, 1'b1);
        push_word(32'hffffffff, 3'd4, 1'b1);      // single full word
        push_word(32'h87654321, 3'd5, 1'b1);      // excess counts saturate
        push_word(32'h87654321, 3'd6, 1'b1);
        push_word(32'h87654321, 3'd7, 1'b1);
        push_word(32'h00000000, 3'd0, 1'b0);      // body word ignores count
        push_word(32'hffffffff, 3'd7, 1'b0);
        push_word(32'ha5a5a5a5, 3'd2, 1'b0);
        push_word(32'h5a5a5a5a, 3'd3, 1'b1);
        push_word(32'h00000000, 3'd4, 1'b1);

        // Seed write in the middle of a key restarts it
        push_word(rand_word(), 3'd4, 1'b0);
        push_word(rand_word(), 3'd4, 1'b0);
        settle();
        write_seed(32'h0);
        push_word(rand_word(), 3'd3, 1'b1);
        push_word(rand_word(), 3'd0, 1'b1);
        settle();
        write_seed(32'hffffffff);
        push_word(32'hffffffff, 3'd4, 1'b0);
        push_word(32'h00000000, 3'd0, 1'b1);
        push_word(rand_word(), 3'd2, 1'b1);

        // Random keys, a new seed per phase; the last phase runs without gaps
        for (int ph = 0; ph < 6; ph++) begin
            settle();
            case (ph)
                0:       seed_pick = 32'h0;
                1:       seed_pick = 32'hffffffff;
                2:       seed_pick = SEED_INIT;
                default: seed_pick = $urandom;
            endcase
            write_seed(seed_pick);
            pace_src  = (ph == 5) ? 1'b0 : 1'($urandom_range(0, 1));
            pace_sink = (ph == 5) ? 1'b0 : 1'($urandom_range(0, 1));
            sent = 0;
            while (sent < 92) begin
                klen = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 6);
                repeat (klen) push_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
                tail = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
                push_word(rand_word(), tail, 1'b1);
                sent += klen + 1;
            end
        end

        settle();
        run_end <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS murmur3_word_hash");
        else
            $display("FAIL murmur3_word_hash");
        $finish;
    end

endmodule

### files.f
rtl/mwh_pkg.sv
rtl/mwh_front.sv
rtl/mwh_queue.sv
rtl/mwh_back.sv
rtl/murmur3_word_hash.sv
bench/murmur3_hash_checker.sv
bench/tb.sv
